// File: rtl/fscm_pkg.sv
// Shared types and constants for the fan speed controller with setpoint menu.
`default_nettype none

package fscm_pkg;

   // Menu positions.
   localparam int MENU_W = 4;
   localparam logic [MENU_W-1:0] MENU_MAN_HOME    = 4'd0;
   localparam logic [MENU_W-1:0] MENU_TOP         = 4'd1;
   localparam logic [MENU_W-1:0] MENU_LIMITS      = 4'd2;
   localparam logic [MENU_W-1:0] MENU_EDIT_MAX    = 4'd3;
   localparam logic [MENU_W-1:0] MENU_LIMIT_MIN   = 4'd4;
   localparam logic [MENU_W-1:0] MENU_EDIT_MIN    = 4'd5;
   localparam logic [MENU_W-1:0] MENU_SOURCE      = 4'd6;
   localparam logic [MENU_W-1:0] MENU_AUTO_LOCAL  = 4'd7;
   localparam logic [MENU_W-1:0] MENU_AUTO_REMOTE = 4'd8;
   localparam logic [MENU_W-1:0] MENU_MAN_LOCAL   = 4'd9;
   localparam logic [MENU_W-1:0] MENU_MAN_REMOTE  = 4'd10;

   // Button codes, in priority order.
   localparam logic [1:0] BTN_ENTER = 2'd0;
   localparam logic [1:0] BTN_UP    = 2'd1;
   localparam logic [1:0] BTN_DOWN  = 2'd2;
   localparam logic [1:0] BTN_NONE  = 2'd3;

   // Switch history code that matches neither switch level.
   localparam logic [1:0] SWITCH_UNSEEN = 2'd2;

   // Register indexes on the configuration port.
   localparam logic CSR_CEILING = 1'b0;
   localparam logic CSR_ENABLE  = 1'b1;

   // Reset values.
   localparam logic signed [15:0] HELD_TEMP_RESET = 16'sd15984;
   localparam logic [7:0] UPPER_RESET   = 8'd70;
   localparam logic [7:0] LOWER_RESET   = 8'd40;
   localparam logic [7:0] CEILING_RESET = 8'd100;
   localparam logic [6:0] ENABLE_RESET  = 7'd5;

   // Widths of the automatic-mode division operands.
   localparam int AUTO_NUM_W = 18;
   localparam int SPAN_W     = 11;

   // Scaling constants. Each reciprocal is exact over the value range it sees.
   localparam int PCT_GAIN    = 101;
   localparam int SPAN_GAIN   = 265;
   localparam int PCT_MAX     = 100;
   localparam int RECIP_100   = 10486;   // x / 100 == (x * RECIP_100) >> 20
   localparam int RECIP_STEP  = 102820;  // 20 * x / 51 == (x * RECIP_STEP) >> 18
   localparam int RECIP_5     = 205;     // x / 5 == (x * RECIP_5) >> 10
   localparam int DUTY_GAIN   = 51;
   localparam int STEP_GAIN   = 5;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic div_done;
   } dp_status_type;

   // Menu and mode state as shown on the result channel.
   typedef struct packed {
      logic              manual;
      logic [MENU_W-1:0] position;
      logic              remote;
      logic [7:0]        upper;
      logic [7:0]        lower;
      logic [7:0]        edit_upper;
      logic [7:0]        edit_lower;
   } menu_view_type;

endpackage

`default_nettype wire

// File: rtl/fscm_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module fscm_div #(
   parameter int NUM_W = 19,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quot,
   output logic                  done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // Shift the next numerator bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: rtl/fscm_menu.sv
// Mode tracking, button handling and the setpoint menu state.
`default_nettype none

module fscm_menu
   import fscm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic          mode_switch,
   input  wire logic          enter_button,
   input  wire logic          up_button,
   input  wire logic          down_button,
   input  wire logic [7:0]    ceiling,
   output logic               manual_next,
   output menu_view_type      view
);

   logic [1:0]        sw_seen_ff, sw_seen_in;
   logic              manual_ff, manual_in;
   logic [MENU_W-1:0] state_ff, state_in;
   logic [2:0]        armed_ff, armed_in;
   logic [7:0]        upper_ff, upper_in;
   logic [7:0]        lower_ff, lower_in;
   logic [7:0]        upend_ff, upend_in;
   logic [7:0]        lpend_ff, lpend_in;
   logic              remote_ff, remote_in;

   logic [MENU_W-1:0] state_mode;
   logic [2:0]        level;
   logic [2:0]        armed_lvl;
   logic [2:0]        handled;
   logic [2:0]        act;
   logic [1:0]        btn;
   logic              ent;
   logic              up;

   always_comb begin
      sw_seen_in = sw_seen_ff;
      manual_in  = manual_ff;
      state_mode = state_ff;
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      upend_in   = upend_ff;
      lpend_in   = lpend_ff;
      remote_in  = remote_ff;

      // A switch change moves the mode and pulls the menu into that mode's states.
      if ({1'b0, mode_switch} != sw_seen_ff) begin
         sw_seen_in = {1'b0, mode_switch};
         if (!mode_switch) begin
            manual_in = 1'b0;
            if (state_ff == MENU_MAN_HOME || state_ff == MENU_MAN_LOCAL ||
                state_ff == MENU_MAN_REMOTE) begin
               state_mode = MENU_TOP;
            end
         end else begin
            manual_in = 1'b1;
            if (state_ff >= MENU_TOP && state_ff <= MENU_AUTO_REMOTE) begin
               state_mode = MENU_MAN_HOME;
            end
         end
      end

      // Released buttons re-arm; pick the first armed, pressed and handled one.
      level     = {down_button, up_button, enter_button};
      armed_lvl = armed_ff | level;
      if (manual_in) begin
         if (state_mode == MENU_MAN_HOME) begin
            handled = 3'b001;
         end else if (state_mode == MENU_MAN_LOCAL || state_mode == MENU_MAN_REMOTE) begin
            handled = 3'b111;
         end else begin
            handled = 3'b000;
         end
      end else begin
         handled = (state_mode >= MENU_TOP && state_mode <= MENU_AUTO_REMOTE) ? 3'b111 : 3'b000;
      end
      act = ~level & armed_lvl & handled;
      if (act[0]) begin
         btn = BTN_ENTER;
      end else if (act[1]) begin
         btn = BTN_UP;
      end else if (act[2]) begin
         btn = BTN_DOWN;
      end else begin
         btn = BTN_NONE;
      end

      armed_in = armed_lvl;
      case (btn)
         BTN_ENTER: armed_in[0] = 1'b0;
         BTN_UP:    armed_in[1] = 1'b0;
         BTN_DOWN:  armed_in[2] = 1'b0;
         default:   armed_in = armed_lvl;
      endcase

      ent = btn == BTN_ENTER;
      up  = btn == BTN_UP;

      // Menu action for the chosen button.
      state_in = state_mode;
      if (btn != BTN_NONE) begin
         case (state_mode)
            MENU_MAN_HOME: begin
               if (ent) state_in = MENU_MAN_LOCAL;
            end
            MENU_TOP:       state_in = ent ? MENU_LIMITS : MENU_SOURCE;
            MENU_LIMITS:    state_in = ent ? MENU_EDIT_MAX : MENU_LIMIT_MIN;
            MENU_EDIT_MAX: begin
               if (ent) begin
                  upper_in = upend_ff;
                  state_in = MENU_TOP;
               end else if (up) begin
                  upend_in = (upend_ff >= ceiling) ? ceiling : upend_ff + 8'd1;
               end else begin
                  upend_in = (upend_ff <= lower_ff) ? lower_ff : upend_ff - 8'd1;
               end
            end
            MENU_LIMIT_MIN: state_in = ent ? MENU_EDIT_MIN : MENU_LIMITS;
            MENU_EDIT_MIN: begin
               if (ent) begin
                  lower_in = lpend_ff;
                  state_in = MENU_TOP;
               end else if (up) begin
                  lpend_in = (lpend_ff >= upper_ff) ? upper_ff : lpend_ff + 8'd1;
               end else begin
                  lpend_in = (lpend_ff == 8'd0) ? 8'd0 : lpend_ff - 8'd1;
               end
            end
            MENU_SOURCE:    state_in = ent ? MENU_AUTO_LOCAL : MENU_TOP;
            MENU_AUTO_LOCAL: begin
               if (ent) begin
                  remote_in = 1'b0;
                  state_in  = MENU_TOP;
               end else begin
                  state_in = MENU_AUTO_REMOTE;
               end
            end
            MENU_AUTO_REMOTE: begin
               if (ent) begin
                  remote_in = 1'b1;
                  state_in  = MENU_TOP;
               end else begin
                  state_in = MENU_AUTO_LOCAL;
               end
            end
            MENU_MAN_LOCAL: begin
               if (ent) begin
                  remote_in = 1'b0;
                  state_in  = MENU_MAN_HOME;
               end else begin
                  state_in = MENU_MAN_REMOTE;
               end
            end
            MENU_MAN_REMOTE: begin
               if (ent) begin
                  remote_in = 1'b1;
                  state_in  = MENU_MAN_HOME;
               end else begin
                  state_in = MENU_MAN_LOCAL;
               end
            end
            default: state_in = state_mode;
         endcase
      end
   end

   // State moves once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_seen_ff <= SWITCH_UNSEEN;
         manual_ff  <= 1'b0;
         state_ff   <= MENU_MAN_HOME;
         armed_ff   <= 3'b111;
         upper_ff   <= UPPER_RESET;
         lower_ff   <= LOWER_RESET;
         upend_ff   <= UPPER_RESET;
         lpend_ff   <= LOWER_RESET;
         remote_ff  <= 1'b0;
      end else if (accept) begin
         sw_seen_ff <= sw_seen_in;
         manual_ff  <= manual_in;
         state_ff   <= state_in;
         armed_ff   <= armed_in;
         upper_ff   <= upper_in;
         lower_ff   <= lower_in;
         upend_ff   <= upend_in;
         lpend_ff   <= lpend_in;
         remote_ff  <= remote_in;
      end
   end

   assign manual_next     = manual_in;
   assign view.manual     = manual_ff;
   assign view.position   = state_ff;
   assign view.remote     = remote_ff;
   assign view.upper      = upper_ff;
   assign view.lower      = lower_ff;
   assign view.edit_upper = upend_ff;
   assign view.edit_lower = lpend_ff;

endmodule

`default_nettype wire

// File: rtl/fscm_datapath.sv
// Speed datapath: held temperature, percent division, scaling and result register.
`default_nettype none

module fscm_datapath
   import fscm_pkg::*;
#(
   parameter int POT_BITS = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dp_cmd_type                 cmd,
   output dp_status_type                   status,
   input  wire logic signed [12:0]         temperature_q4,
   input  wire logic                       temp_valid,
   input  wire logic        [POT_BITS-1:0] pot_value,
   input  wire logic                       manual_next,
   input  wire menu_view_type              view,
   input  wire logic        [6:0]          enable_percent,
   output logic             [7:0]          pwm_duty,
   output logic             [6:0]          speed_percent,
   output logic                            fan_enable,
   output menu_view_type                   view_out
);

   localparam int NUM_W   = (POT_BITS + 9 > AUTO_NUM_W) ? POT_BITS + 9 : AUTO_NUM_W;
   localparam int DEN_W   = (POT_BITS > SPAN_W) ? POT_BITS : SPAN_W;
   localparam int POT_MAX = (1 << POT_BITS) - 1;

   logic signed [15:0]    held_ff;
   logic                  manual_ff;
   logic [POT_BITS-1:0]   pot_ff;
   logic [7:0]            lo_ff;
   logic [7:0]            hi_ff;
   logic                  fixed_ff;
   logic [6:0]            fixed_pct_ff;
   logic [14:0]           p1_ff;
   logic [8:0]            s_ff;
   logic [6:0]            val_ff;
   logic [4:0]            q5_ff;
   logic [7:0]            duty_ff;
   logic [6:0]            speed_ff;
   logic                  enable_ff;
   menu_view_type         view_ff;

   logic signed [15:0]    lo8;
   logic signed [15:0]    hi8;
   logic signed [15:0]    diff;
   logic [SPAN_W-1:0]     span;
   logic [AUTO_NUM_W-1:0] auto_num;
   logic [NUM_W-1:0]      man_num;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic                  below;
   logic                  above;
   logic                  fixed_in;
   logic [6:0]            fixed_pct_in;
   logic [NUM_W-1:0]      quot;
   logic [6:0]            div_pct;
   logic [6:0]            pct;
   logic [14:0]           auto_scaled;
   logic [28:0]           prod2;
   logic [25:0]           prod3;
   logic [14:0]           prod4;
   logic [9:0]            duty_prod;
   logic [6:0]            val_clamped;

   // Threshold bounds in sixteenths of a degree.
   assign lo8   = signed'({5'd0, lo_ff, 3'd0});
   assign hi8   = signed'({5'd0, hi_ff, 3'd0});
   assign below = held_ff < lo8;
   assign above = held_ff > hi8;
   assign diff  = held_ff - lo8;
   assign span  = {8'(hi_ff - lo_ff), 3'd0};

   // Divider operands for either mode.
   assign auto_num = AUTO_NUM_W'(diff[SPAN_W-1:0]) * AUTO_NUM_W'(PCT_GAIN);
   assign man_num  = NUM_W'(pot_ff) * NUM_W'(SPAN_GAIN);
   assign div_num  = manual_ff ? man_num : NUM_W'(auto_num);
   assign div_den  = manual_ff ? DEN_W'(POT_MAX) : DEN_W'(span);

   // In automatic mode, out-of-range temperatures and a zero span bypass the quotient.
   always_comb begin
      fixed_in     = 1'b0;
      fixed_pct_in = 7'd0;
      if (!manual_ff) begin
         if (below) begin
            fixed_in = 1'b1;
         end else if (above) begin
            fixed_in     = 1'b1;
            fixed_pct_in = 7'(PCT_MAX);
         end else if (span == '0) begin
            fixed_in = 1'b1;
         end
      end
   end

   fscm_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .done  (status.div_done)
   );

   // Scaling chain, one registered step per command; in manual mode the first two steps pass the quotient through.
   assign div_pct     = (quot > NUM_W'(PCT_MAX)) ? 7'(PCT_MAX) : quot[6:0];
   assign pct         = fixed_ff ? fixed_pct_ff : div_pct;
   assign auto_scaled = 15'(pct) * 15'(SPAN_GAIN);
   assign prod2       = 29'(p1_ff) * 29'(RECIP_100);
   assign prod3       = 26'(s_ff) * 26'(RECIP_STEP);
   assign prod4       = 15'(val_ff) * 15'(RECIP_5);
   assign duty_prod   = 10'(q5_ff) * 10'(DUTY_GAIN);
   assign val_clamped = (val_ff > 7'(PCT_MAX)) ? 7'(PCT_MAX) : val_ff;

   // Held temperature is state and survives between beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_TEMP_RESET;
      end else if (cmd.load && temp_valid) begin
         held_ff <= 16'(temperature_q4);
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         manual_ff <= manual_next;
         pot_ff    <= pot_value;
         lo_ff     <= view.lower;
         hi_ff     <= view.upper;
      end
      if (cmd.div_start) begin
         fixed_ff     <= fixed_in;
         fixed_pct_ff <= fixed_pct_in;
      end
      if (cmd.mul1) begin
         p1_ff <= manual_ff ? 15'(quot[8:0]) : auto_scaled;
      end
      if (cmd.mul2) begin
         s_ff <= manual_ff ? p1_ff[8:0] : prod2[28:20];
      end
      if (cmd.mul3) begin
         val_ff <= prod3[24:18];
      end
      if (cmd.mul4) begin
         q5_ff <= prod4[14:10];
      end
      if (cmd.out_load) begin
         duty_ff   <= duty_prod[9:2];
         speed_ff  <= 7'(q5_ff) * 7'(STEP_GAIN);
         enable_ff <= val_clamped >= enable_percent;
         view_ff   <= view;
      end
   end

   assign pwm_duty      = duty_ff;
   assign speed_percent = speed_ff;
   assign fan_enable    = enable_ff;
   assign view_out      = view_ff;

endmodule

`default_nettype wire

// File: rtl/fscm_ctrl.sv
// Sequencer that steps the datapath through one control tick per beat.
`default_nettype none

module fscm_ctrl
   import fscm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL1 = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_MUL3 = 3'd5;
   localparam logic [2:0] ST_MUL4 = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.mul4 = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result beat valid flag.
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/fan_speed_controller_with_setpoint_menu_top.sv
// Top level of the fan speed controller with setpoint menu.
//
// Each request beat is one control tick. The block takes one beat at a time: a
// beat is accepted, a setup cycle starts the divider, then the fan percent goes
// through a restoring serial divider that makes one quotient bit per cycle. The
// done flag is registered and handed to the sequencer, then come four scaling
// steps and the result cycle. The next beat is taken in the cycle after the
// result is written to the output register, even if the response side is still
// stalling. A result that is still stalled when the next one is ready holds the
// sequencer in its result cycle. Menu, mode and button state move at the
// acceptance edge; the thresholds used for the speed are those in force before
// any button action of the same tick. Registers: setpoint_ceiling at byte
// address 0, enable_percent at address 4.
`default_nettype none

module fan_speed_controller_with_setpoint_menu_top
   import fscm_pkg::*;
#(
   parameter int POT_BITS = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Request channel.
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [12:0]         req_temperature_q4,
   input  wire logic                       req_temp_valid,
   input  wire logic        [POT_BITS-1:0] req_pot_value,
   input  wire logic                       req_mode_switch,
   input  wire logic                       req_enter_button,
   input  wire logic                       req_up_button,
   input  wire logic                       req_down_button,
   // Response channel.
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic             [7:0]          rsp_pwm_duty,
   output logic             [6:0]          rsp_speed_percent,
   output logic                            rsp_fan_enable,
   output logic                            rsp_manual_active,
   output logic             [3:0]          rsp_menu_position,
   output logic                            rsp_remote_source,
   output logic             [7:0]          rsp_upper_threshold,
   output logic             [7:0]          rsp_lower_threshold,
   output logic             [7:0]          rsp_edit_upper,
   output logic             [7:0]          rsp_edit_lower,
   // Configuration port.
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic        [2:0]          csr_paddr,
   input  wire logic        [31:0]         csr_pwdata,
   output logic             [31:0]         csr_prdata,
   output logic                            csr_pready
);

   logic          csr_index;
   logic [7:0]    ceiling_reg_ff;
   logic [6:0]    enable_reg_ff;
   logic          csr_write;
   logic          accept;
   logic          manual_next;
   dp_cmd_type    cmd;
   dp_status_type status;
   menu_view_type view;
   menu_view_type view_out;

   // Configuration registers, word aligned.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_reg_ff <= CEILING_RESET;
         enable_reg_ff  <= ENABLE_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_CEILING) begin
            ceiling_reg_ff <= csr_pwdata[7:0];
         end else begin
            enable_reg_ff <= csr_pwdata[6:0];
         end
      end
   end

   assign csr_prdata = (csr_index == CSR_ENABLE) ? {25'd0, enable_reg_ff}
                                                  : {24'd0, ceiling_reg_ff};

   assign accept = req_valid & ~req_stall;

   fscm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fscm_menu u_menu (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .mode_switch  (req_mode_switch),
      .enter_button (req_enter_button),
      .up_button    (req_up_button),
      .down_button  (req_down_button),
      .ceiling      (ceiling_reg_ff),
      .manual_next  (manual_next),
      .view         (view)
   );

   fscm_datapath #(
      .POT_BITS (POT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .temperature_q4 (req_temperature_q4),
      .temp_valid     (req_temp_valid),
      .pot_value      (req_pot_value),
      .manual_next    (manual_next),
      .view           (view),
      .enable_percent (enable_reg_ff),
      .pwm_duty       (rsp_pwm_duty),
      .speed_percent  (rsp_speed_percent),
      .fan_enable     (rsp_fan_enable),
      .view_out       (view_out)
   );

   assign rsp_manual_active   = view_out.manual;
   assign rsp_menu_position   = view_out.position;
   assign rsp_remote_source   = view_out.remote;
   assign rsp_upper_threshold = view_out.upper;
   assign rsp_lower_threshold = view_out.lower;
   assign rsp_edit_upper      = view_out.edit_upper;
   assign rsp_edit_lower      = view_out.edit_lower;

endmodule

`default_nettype wire

// File: rtl/fscm_checker.sv
// Port-level checks on the fan speed controller top level, with its bind.
`default_nettype none

module fscm_checker
   import fscm_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [6:0] rsp_speed_percent,
   input wire logic       rsp_manual_active,
   input wire logic [3:0] rsp_menu_position
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Only one tick is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a tick is in work");

   // In automatic mode the menu sits in the automatic states only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_manual_active |->
         rsp_menu_position >= MENU_TOP && rsp_menu_position <= MENU_AUTO_REMOTE)
      else $error("automatic mode shows a manual menu position");

   // In manual mode the menu sits in the manual states only, and speed stays in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_manual_active |->
         (rsp_menu_position == MENU_MAN_HOME || rsp_menu_position == MENU_MAN_LOCAL ||
          rsp_menu_position == MENU_MAN_REMOTE) && rsp_speed_percent <= 7'd100)
      else $error("manual mode shows a bad menu position or speed");

endmodule

bind fan_speed_controller_with_setpoint_menu_top fscm_checker u_fscm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_speed_percent (rsp_speed_percent),
   .rsp_manual_active (rsp_manual_active),
   .rsp_menu_position (rsp_menu_position)
);

`default_nettype wire
